@@ rtl/tls_client_hello_sni_extractor_defines.svh @@
// Assertion macros shared by the TLS server-name extractor RTL.
// Depends on nothing; files that check their logic include it.
`ifndef TLS_CLIENT_HELLO_SNI_EXTRACTOR_DEFINES_SVH
`define TLS_CLIENT_HELLO_SNI_EXTRACTOR_DEFINES_SVH

// Checked at every rising clock edge, ignored while reset is asserted.
`define TCSE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included.
`define TCSE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/tcse_pkg.sv @@
// Types and constants of the TLS server-name extractor.
// Used by the parser core and the top level; depends on nothing.
package tcse_pkg;

  typedef enum logic [15:0] {
    PS_REC_TYPE  = 16'h0001,
    PS_REC_VER   = 16'h0002,
    PS_REC_LEN   = 16'h0004,
    PS_HS_TYPE   = 16'h0008,
    PS_HS_LEN    = 16'h0010,
    PS_HS_VER    = 16'h0020,
    PS_SID       = 16'h0040,
    PS_CIPH      = 16'h0080,
    PS_COMP      = 16'h0100,
    PS_EXT_TOTAL = 16'h0200,
    PS_EXT_TYPE  = 16'h0400,
    PS_EXT_LEN   = 16'h0800,
    PS_SNI_LIST  = 16'h1000,
    PS_SNI_NTYPE = 16'h2000,
    PS_SNI_NLEN  = 16'h4000,
    PS_SNI_NAME  = 16'h8000
  } parse_state_e;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_DUP_SNI    = 2'd1,
    ERR_LIST_SHORT = 2'd2
  } err_e;

  localparam logic [7:0]  RecHandshake   = 8'd22;
  localparam logic [7:0]  HsClientHello  = 8'd1;
  localparam logic [15:0] ExtServerName  = 16'd0;

  typedef struct packed {
    parse_state_e ps;
    logic [1:0]   cnt;
    logic [23:0]  shift;
    logic [23:0]  skip;
    logic [7:0]   rec_type;
    logic [7:0]   hs_type;
    logic [15:0]  ext_total;
    logic [17:0]  ext_cons;
    logic [15:0]  ext_kind;
    logic [15:0]  list_len;
    logic [15:0]  host_rem;
    logic         captured;
    err_e         err;
    logic [31:0]  payload;
  } parse_regs_t;

  localparam parse_regs_t ParseRegsReset = '{
    ps:        PS_REC_TYPE,
    cnt:       2'd0,
    shift:     24'd0,
    skip:      24'd0,
    rec_type:  8'd0,
    hs_type:   8'd0,
    ext_total: 16'd0,
    ext_cons:  18'd0,
    ext_kind:  16'd0,
    list_len:  16'd0,
    host_rem:  16'd0,
    captured:  1'b0,
    err:       ERR_NONE,
    payload:   32'd0
  };

  typedef struct packed {
    logic        name_valid;
    logic [7:0]  name_byte;
    logic        name_last;
    logic        sni_found;
    err_e        error_code;
    logic [31:0] payload_total;
  } result_t;

endpackage

@@ rtl/tls_client_hello_sni_extractor.sv @@
// Top level of the TLS ClientHello server-name extractor.
// Instantiates tcse_parser; depends on tcse_pkg and the assertion macros header.
//
// The input channel takes one stream byte per request on data_byte_i, with
// new_stream_i set on the first byte of a new connection to clear all parser
// state before that byte is parsed. in_valid_i/in_stall_o carry the handshake.
// Every accepted byte yields exactly one result request on the output channel
// (out_valid_o/out_stall_i): the host-name byte flags and byte, the
// sni_found flag, the latched error code and the running sum of record lengths.
// A byte is held in an input register, parsed once the result register can take
// it, and its result is registered at the end of the cycle in which it is parsed.
// One byte is taken every cycle while the receiver does not stall; the parser
// updates its state in the same cycle as the byte's result is registered.
// While the receiver stalls the result register holds its request and the
// input register keeps the next byte, so in_stall_o rises once both are full.
// Reset clears the parser state and empties both registers; no result is
// lost or repeated across a stall.
`include "tls_client_hello_sni_extractor_defines.svh"

module tls_client_hello_sni_extractor #(
  parameter int RANDOM_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        new_stream_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        name_valid_o,
  output logic [7:0]  name_byte_o,
  output logic        name_last_o,
  output logic        sni_found_o,
  output logic [1:0]  error_code_o,
  output logic [31:0] payload_total_o
);
  import tcse_pkg::*;

  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_data_q;
  logic       s1_new_q;
  logic       out_valid_q, out_valid_d;
  result_t    out_res_q;
  result_t    parse_res;
  logic       out_ready, s1_move, s1_stall, in_accept;

  assign out_ready   = !out_valid_q || !out_stall_i;
  assign s1_move     = s1_valid_q && out_ready;
  assign s1_stall    = s1_valid_q && !out_ready;
  assign in_stall_o  = s1_stall;
  assign in_accept   = in_valid_i && !s1_stall;
  assign s1_valid_d  = in_accept || (s1_valid_q && !s1_move);
  assign out_valid_d = s1_move || (out_valid_q && out_stall_i);

  tcse_parser #(
    .RANDOM_BYTES(RANDOM_BYTES)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (s1_move),
    .data_byte_i (s1_data_q),
    .new_stream_i(s1_new_q),
    .result_o    (parse_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_data_q <= data_byte_i;
      s1_new_q  <= new_stream_i;
    end
    if (s1_move) begin
      out_res_q <= parse_res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign name_valid_o    = out_res_q.name_valid;
  assign name_byte_o     = out_res_q.name_byte;
  assign name_last_o     = out_res_q.name_last;
  assign sni_found_o     = out_res_q.sni_found;
  assign error_code_o    = out_res_q.error_code;
  assign payload_total_o = out_res_q.payload_total;

  `TCSE_ASSERT(a_parse_fills_output,
      s1_move |=> out_valid_o,
      "parsed byte did not reach the result register")
  `TCSE_ASSERT(a_empty_output_no_stall,
      !out_valid_o |-> !in_stall_o,
      "input stalled while the result register was empty")
  `TCSE_ASSERT(a_error_no_name,
      out_valid_o && error_code_o != ERR_NONE |-> !name_valid_o,
      "host-name byte reported together with an error")

endmodule

@@ rtl/tcse_parser.sv @@
// Record and ClientHello parser: state registers and the per-byte update.
// Depends on tcse_pkg and the assertion macros header.
`include "tls_client_hello_sni_extractor_defines.svh"

module tcse_parser #(
  parameter int RANDOM_BYTES = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        data_byte_i,
  input  logic              new_stream_i,
  output tcse_pkg::result_t result_o
);
  import tcse_pkg::*;

  parse_regs_t  state_q, state_d, cur;
  parse_state_e ps;
  logic [2:0]   cnt_inc;
  logic         done2, done3;
  logic [23:0]  shift_nx;
  logic [15:0]  word16;
  logic [15:0]  list_rest;
  logic [15:0]  rem_m1;
  logic         nv, nl;
  logic [7:0]   nb;

  assign cur      = new_stream_i ? ParseRegsReset : state_q;
  assign cnt_inc  = {1'b0, cur.cnt} + 3'd1;
  assign done2    = cnt_inc >= 3'd2;
  assign done3    = cnt_inc >= 3'd3;
  assign shift_nx = {cur.shift[15:0], data_byte_i};
  assign word16   = shift_nx[15:0];
  assign list_rest = cur.list_len - word16 - 16'd3;
  assign rem_m1   = cur.host_rem - 16'd1;

  always_comb begin
    state_d = cur;
    ps      = cur.ps;
    nv      = 1'b0;
    nb      = 8'd0;
    nl      = 1'b0;
    if (cur.err != ERR_NONE) begin
      state_d = cur;
    end else if (cur.skip != 24'd0) begin
      state_d.skip = cur.skip - 24'd1;
    end else begin
      if (cur.ps == PS_EXT_TYPE && cur.ext_cons >= {2'b00, cur.ext_total}) begin
        ps = PS_REC_TYPE;
      end
      state_d.ps = ps;
      unique case (ps)
        PS_REC_VER: begin
          state_d.shift = shift_nx;
          state_d.cnt   = done2 ? 2'd0 : cnt_inc[1:0];
          if (done2) begin
            state_d.ps = PS_REC_LEN;
          end
        end
        PS_REC_LEN: begin
          state_d.shift = shift_nx;
          state_d.cnt   = done2 ? 2'd0 : cnt_inc[1:0];
          if (done2) begin
            state_d.payload = cur.payload + {16'd0, word16};
            if (cur.rec_type == RecHandshake) begin
              state_d.ps = PS_HS_TYPE;
            end else begin
              state_d.skip = {8'd0, word16};
              state_d.ps   = PS_REC_TYPE;
            end
          end
        end
        PS_HS_TYPE: begin
          state_d.hs_type = data_byte_i;
          state_d.ps      = PS_HS_LEN;
        end
        PS_HS_LEN: begin
          state_d.shift = shift_nx;
          state_d.cnt   = done3 ? 2'd0 : cnt_inc[1:0];
          if (done3) begin
            if (cur.hs_type != HsClientHello) begin
              state_d.skip = shift_nx;
              state_d.ps   = PS_REC_TYPE;
            end else begin
              state_d.ps = PS_HS_VER;
            end
          end
        end
        PS_HS_VER: begin
          state_d.shift = shift_nx;
          state_d.cnt   = done2 ? 2'd0 : cnt_inc[1:0];
          if (done2) begin
            state_d.skip = 24'(RANDOM_BYTES);
            state_d.ps   = PS_SID;
          end
        end
        PS_SID: begin
          state_d.skip = {16'd0, data_byte_i};
          state_d.ps   = PS_CIPH;
        end
        PS_CIPH: begin
          state_d.shift = shift_nx;
          state_d.cnt   = done2 ? 2'd0 : cnt_inc[1:0];
          if (done2) begin
            state_d.skip = {8'd0, word16};
            state_d.ps   = PS_COMP;
          end
        end
        PS_COMP: begin
          state_d.skip = {16'd0, data_byte_i};
          state_d.ps   = PS_EXT_TOTAL;
        end
        PS_EXT_TOTAL: begin
          state_d.shift = shift_nx;
          state_d.cnt   = done2 ? 2'd0 : cnt_inc[1:0];
          if (done2) begin
            state_d.ext_total = word16;
            state_d.ext_cons  = 18'd0;
            state_d.ps        = PS_EXT_TYPE;
          end
        end
        PS_EXT_TYPE: begin
          state_d.shift = shift_nx;
          state_d.cnt   = done2 ? 2'd0 : cnt_inc[1:0];
          if (done2) begin
            state_d.ext_kind = word16;
            state_d.ps       = PS_EXT_LEN;
          end
        end
        PS_EXT_LEN: begin
          state_d.shift = shift_nx;
          state_d.cnt   = done2 ? 2'd0 : cnt_inc[1:0];
          if (done2) begin
            state_d.ext_cons = cur.ext_cons + {2'b00, word16} + 18'd4;
            if (cur.ext_kind == ExtServerName) begin
              if (cur.captured) begin
                state_d.err = ERR_DUP_SNI;
              end else begin
                state_d.ps = PS_SNI_LIST;
              end
            end else begin
              state_d.skip = {8'd0, word16};
              state_d.ps   = PS_EXT_TYPE;
            end
          end
        end
        PS_SNI_LIST: begin
          state_d.shift = shift_nx;
          state_d.cnt   = done2 ? 2'd0 : cnt_inc[1:0];
          if (done2) begin
            state_d.list_len = word16;
            state_d.ps       = PS_SNI_NTYPE;
          end
        end
        PS_SNI_NTYPE: begin
          state_d.ps = PS_SNI_NLEN;
        end
        PS_SNI_NLEN: begin
          state_d.shift = shift_nx;
          state_d.cnt   = done2 ? 2'd0 : cnt_inc[1:0];
          if (done2) begin
            if ({1'b0, cur.list_len} < ({1'b0, word16} + 17'd3)) begin
              state_d.err = ERR_LIST_SHORT;
            end else begin
              state_d.list_len = list_rest;
              state_d.host_rem = word16;
              if (word16 == 16'd0) begin
                state_d.captured = 1'b1;
                state_d.skip     = {8'd0, list_rest};
                state_d.ps       = PS_EXT_TYPE;
              end else begin
                state_d.ps = PS_SNI_NAME;
              end
            end
          end
        end
        PS_SNI_NAME: begin
          nv               = 1'b1;
          nb               = data_byte_i;
          state_d.host_rem = rem_m1;
          if (rem_m1 == 16'd0) begin
            nl               = 1'b1;
            state_d.captured = 1'b1;
            state_d.skip     = {8'd0, cur.list_len};
            state_d.ps       = PS_EXT_TYPE;
          end
        end
        default: begin
          state_d.rec_type = data_byte_i;
          state_d.cnt      = 2'd0;
          state_d.ps       = PS_REC_VER;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ParseRegsReset;
    end else if (step_i) begin
      state_q <= state_d;
    end
  end

  assign result_o.name_valid    = nv;
  assign result_o.name_byte     = nb;
  assign result_o.name_last     = nl;
  assign result_o.sni_found     = state_d.captured;
  assign result_o.error_code    = state_d.err;
  assign result_o.payload_total = state_d.payload;

  `TCSE_ASSERT(a_error_freezes,
      step_i && !new_stream_i && state_q.err != ERR_NONE |=> state_q == $past(state_q),
      "parser state changed while an error was latched")
  `TCSE_ASSERT(a_skip_counts_down,
      step_i && !new_stream_i && state_q.err == ERR_NONE && state_q.skip != 24'd0
      |=> state_q.skip == $past(state_q.skip) - 24'd1 && state_q.ps == $past(state_q.ps),
      "skip counter did not count down by one")
  `TCSE_ASSERT_ALWAYS(a_last_has_valid,
      result_o.name_last |-> result_o.name_valid && result_o.sni_found,
      "last name byte without a valid name byte")

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for tls_client_hello_sni_extractor: TLS byte streams go in,
// one result per byte comes out and is checked against a cycle-free predictor.
// Depends on tcse_pkg and the extractor RTL only.
`timescale 1ns / 1ps

module tb_top;
  import tcse_pkg::*;

  localparam int RandomBytes = 32;
  localparam int ByteTarget = 1800;

  typedef enum int {
    PLAN_NONE,
    PLAN_NAME,
    PLAN_EMPTY,
    PLAN_SHORT,
    PLAN_TWICE
  } hello_plan_e;

  typedef enum int {
    SNI_OK,
    SNI_EMPTY,
    SNI_SHORT
  } sni_style_e;

  typedef struct packed {
    logic [7:0] data;
    logic       fresh;
  } stream_byte_t;

  typedef struct packed {
    parse_state_e ps;
    logic [1:0]   cnt;
    logic [23:0]  shift;
    logic [23:0]  skip;
    logic [7:0]   rec_type;
    logic [7:0]   hs_type;
    logic [15:0]  ext_total;
    logic [17:0]  ext_cons;
    logic [15:0]  ext_kind;
    logic [15:0]  list_len;
    logic [15:0]  host_rem;
    logic         captured;
    err_e         err;
    logic [31:0]  payload;
  } hello_regs_t;

  localparam hello_regs_t HelloRegsReset = '{
    ps:        PS_REC_TYPE,
    cnt:       2'd0,
    shift:     24'd0,
    skip:      24'd0,
    rec_type:  8'd0,
    hs_type:   8'd0,
    ext_total: 16'd0,
    ext_cons:  18'd0,
    ext_kind:  16'd0,
    list_len:  16'd0,
    host_rem:  16'd0,
    captured:  1'b0,
    err:       ERR_NONE,
    payload:   32'd0
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic [7:0]  data_byte_i = 8'd0;
  logic        new_stream_i = 1'b0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        name_valid_o;
  logic [7:0]  name_byte_o;
  logic        name_last_o;
  logic        sni_found_o;
  logic [1:0]  error_code_o;
  logic [31:0] payload_total_o;

  stream_byte_t byte_backlog[$];
  result_t      predicted_results[$];
  logic [7:0]   ext_buf[$];
  hello_regs_t  hello_st = HelloRegsReset;
  bit           open_stream = 1'b0;

  int unsigned bytes_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned name_bytes = 0;
  int unsigned names_done = 0;
  int unsigned dup_errors = 0;
  int unsigned short_errors = 0;

  tls_client_hello_sni_extractor #(
    .RANDOM_BYTES(RandomBytes)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .new_stream_i   (new_stream_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .name_valid_o   (name_valid_o),
    .name_byte_o    (name_byte_o),
    .name_last_o    (name_last_o),
    .sni_found_o    (sni_found_o),
    .error_code_o   (error_code_o),
    .payload_total_o(payload_total_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor of the parser.

  function automatic bit take_field(input int need, input logic [7:0] b);
    hello_st.shift = {hello_st.shift[15:0], b};
    if (int'(hello_st.cnt) + 1 >= need) begin
      hello_st.cnt = 2'd0;
      return 1'b1;
    end
    hello_st.cnt = hello_st.cnt + 2'd1;
    return 1'b0;
  endfunction

  function automatic void open_name(input logic [15:0] nlen);
    if ({1'b0, hello_st.list_len} < {1'b0, nlen} + 17'd3) begin
      hello_st.err = ERR_LIST_SHORT;
    end else begin
      hello_st.list_len = hello_st.list_len - nlen - 16'd3;
      hello_st.host_rem = nlen;
      if (nlen == 16'd0) begin
        hello_st.captured = 1'b1;
        hello_st.skip = {8'd0, hello_st.list_len};
        hello_st.ps = PS_EXT_TYPE;
      end else begin
        hello_st.ps = PS_SNI_NAME;
      end
    end
  endfunction

  function automatic result_t sni_predict(input logic [7:0] b, input logic fresh);
    result_t     r;
    logic [15:0] v16;
    logic [23:0] v24;
    r.name_valid = 1'b0;
    r.name_byte = 8'd0;
    r.name_last = 1'b0;
    if (fresh) hello_st = HelloRegsReset;
    if (hello_st.err != ERR_NONE) begin
    end else if (hello_st.skip != 24'd0) begin
      hello_st.skip = hello_st.skip - 24'd1;
    end else begin
      if (hello_st.ps == PS_EXT_TYPE && hello_st.ext_cons >= {2'b00, hello_st.ext_total})
        hello_st.ps = PS_REC_TYPE;
      case (hello_st.ps)
        PS_REC_VER: begin
          if (take_field(2, b)) hello_st.ps = PS_REC_LEN;
        end
        PS_REC_LEN: begin
          if (take_field(2, b)) begin
            v16 = hello_st.shift[15:0];
            hello_st.payload = hello_st.payload + {16'd0, v16};
            if (hello_st.rec_type == RecHandshake) begin
              hello_st.ps = PS_HS_TYPE;
            end else begin
              hello_st.skip = {8'd0, v16};
              hello_st.ps = PS_REC_TYPE;
            end
          end
        end
        PS_HS_TYPE: begin
          hello_st.hs_type = b;
          hello_st.ps = PS_HS_LEN;
        end
        PS_HS_LEN: begin
          if (take_field(3, b)) begin
            v24 = hello_st.shift;
            if (hello_st.hs_type != HsClientHello) begin
              hello_st.skip = v24;
              hello_st.ps = PS_REC_TYPE;
            end else begin
              hello_st.ps = PS_HS_VER;
            end
          end
        end
        PS_HS_VER: begin
          if (take_field(2, b)) begin
            hello_st.skip = 24'(RandomBytes);
            hello_st.ps = PS_SID;
          end
        end
        PS_SID: begin
          hello_st.skip = {16'd0, b};
          hello_st.ps = PS_CIPH;
        end
        PS_CIPH: begin
          if (take_field(2, b)) begin
            hello_st.skip = {8'd0, hello_st.shift[15:0]};
            hello_st.ps = PS_COMP;
          end
        end
        PS_COMP: begin
          hello_st.skip = {16'd0, b};
          hello_st.ps = PS_EXT_TOTAL;
        end
        PS_EXT_TOTAL: begin
          if (take_field(2, b)) begin
            hello_st.ext_total = hello_st.shift[15:0];
            hello_st.ext_cons = 18'd0;
            hello_st.ps = PS_EXT_TYPE;
          end
        end
        PS_EXT_TYPE: begin
          if (take_field(2, b)) begin
            hello_st.ext_kind = hello_st.shift[15:0];
            hello_st.ps = PS_EXT_LEN;
          end
        end
        PS_EXT_LEN: begin
          if (take_field(2, b)) begin
            v16 = hello_st.shift[15:0];
            hello_st.ext_cons = hello_st.ext_cons + {2'b00, v16} + 18'd4;
            if (hello_st.ext_kind == ExtServerName) begin
              if (hello_st.captured) hello_st.err = ERR_DUP_SNI;
              else hello_st.ps = PS_SNI_LIST;
            end else begin
              hello_st.skip = {8'd0, v16};
              hello_st.ps = PS_EXT_TYPE;
            end
          end
        end
        PS_SNI_LIST: begin
          if (take_field(2, b)) begin
            hello_st.list_len = hello_st.shift[15:0];
            hello_st.ps = PS_SNI_NTYPE;
          end
        end
        PS_SNI_NTYPE: begin
          hello_st.ps = PS_SNI_NLEN;
        end
        PS_SNI_NLEN: begin
          if (take_field(2, b)) open_name(hello_st.shift[15:0]);
        end
        PS_SNI_NAME: begin
          r.name_valid = 1'b1;
          r.name_byte = b;
          hello_st.host_rem = hello_st.host_rem - 16'd1;
          if (hello_st.host_rem == 16'd0) begin
            r.name_last = 1'b1;
            hello_st.captured = 1'b1;
            hello_st.skip = {8'd0, hello_st.list_len};
            hello_st.ps = PS_EXT_TYPE;
          end
        end
        default: begin
          hello_st.rec_type = b;
          hello_st.cnt = 2'd0;
          hello_st.ps = PS_REC_VER;
        end
      endcase
    end
    r.sni_found = hello_st.captured;
    r.error_code = hello_st.err;
    r.payload_total = hello_st.payload;
    return r;
  endfunction

  // Stream builders.

  task automatic put_byte(input logic [7:0] b);
    byte_backlog.push_back('{data: b, fresh: open_stream});
    open_stream = 1'b0;
  endtask

  task automatic put_word(input logic [15:0] w);
    put_byte(w[15:8]);
    put_byte(w[7:0]);
  endtask

  task automatic put_junk(input int n);
    repeat (n) put_byte(8'($urandom));
  endtask

  task automatic ext_word(input logic [15:0] w);
    ext_buf.push_back(w[15:8]);
    ext_buf.push_back(w[7:0]);
  endtask

  task automatic add_plain_ext();
    logic [15:0] kind;
    int          len;
    kind = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom_range(1, 65535));
    len = $urandom_range(0, 6);
    ext_word(kind);
    ext_word(16'(len));
    repeat (len) ext_buf.push_back(8'($urandom));
  endtask

  task automatic add_sni_ext(input sni_style_e style);
    logic [15:0] nlen;
    logic [15:0] list;
    int          rem;
    nlen = (style == SNI_EMPTY) ? 16'd0 : 16'($urandom_range(1, 12));
    rem = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    if (style == SNI_SHORT) begin
      if ($urandom_range(0, 3) == 0) nlen = 16'hFFFF;
      list = 16'($urandom_range(0, 5));
      if (nlen != 16'hFFFF && list > nlen + 16'd2) list = nlen + 16'd2;
    end else begin
      list = nlen + 16'd3 + 16'(rem);
    end
    ext_word(ExtServerName);
    ext_word(list + 16'd2);
    ext_word(list);
    ext_buf.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd0);
    ext_word(nlen);
    if (style != SNI_SHORT) begin
      repeat (nlen) ext_buf.push_back(8'($urandom));
      repeat (rem) ext_buf.push_back(8'($urandom));
    end
  endtask

  task automatic put_client_hello(input hello_plan_e plan);
    int          nplain;
    int          sni_at;
    int          sid;
    int          ciph;
    int          comp;
    logic [15:0] total;
    ext_buf.delete();
    nplain = $urandom_range(0, 3);
    sni_at = $urandom_range(0, nplain);
    for (int i = 0; i <= nplain; i++) begin
      if (i == sni_at) begin
        case (plan)
          PLAN_NAME, PLAN_TWICE: add_sni_ext(SNI_OK);
          PLAN_EMPTY: add_sni_ext(SNI_EMPTY);
          PLAN_SHORT: add_sni_ext(SNI_SHORT);
          default: ;
        endcase
      end
      if (i < nplain) add_plain_ext();
    end
    if (plan == PLAN_TWICE) add_sni_ext(SNI_OK);
    total = 16'(ext_buf.size());
    if ($urandom_range(0, 9) == 0) total = 16'($urandom_range(0, ext_buf.size()));
    put_byte(RecHandshake);
    put_word(16'($urandom));
    put_word(16'($urandom));
    put_byte(HsClientHello);
    put_junk(3);
    put_word(16'($urandom));
    put_junk(RandomBytes);
    sid = ($urandom_range(0, 7) == 0) ? 32 : $urandom_range(0, 4);
    put_byte(8'(sid));
    put_junk(sid);
    ciph = 2 * $urandom_range(0, 3);
    put_word(16'(ciph));
    put_junk(ciph);
    comp = $urandom_range(0, 2);
    put_byte(8'(comp));
    put_junk(comp);
    put_word(total);
    foreach (ext_buf[i]) put_byte(ext_buf[i]);
  endtask

  task automatic put_other_record();
    logic [7:0] kind;
    int         len;
    kind = 8'($urandom);
    if (kind == RecHandshake) kind = kind + 8'd1;
    len = $urandom_range(0, 10);
    put_byte(kind);
    put_word(16'($urandom));
    put_word(16'(len));
    put_junk(len);
  endtask

  task automatic put_other_handshake();
    logic [7:0]  kind;
    logic [23:0] len;
    kind = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(2, 255));
    len = 24'($urandom_range(0, 10));
    put_byte(RecHandshake);
    put_word(16'($urandom));
    put_word(16'($urandom));
    put_byte(kind);
    put_byte(len[23:16]);
    put_byte(len[15:8]);
    put_byte(len[7:0]);
    put_junk(int'(len));
  endtask

  task automatic put_stream(input hello_plan_e plan);
    open_stream = 1'b1;
    if ($urandom_range(0, 1) == 0) put_other_record();
    put_client_hello(plan);
    if ($urandom_range(0, 9) < 3) put_client_hello(hello_plan_e'($urandom_range(0, 4)));
    if ($urandom_range(0, 9) < 4) begin
      if ($urandom_range(0, 1) == 0) put_other_record();
      else put_other_handshake();
    end
  endtask

  function automatic hello_plan_e pick_plan();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return PLAN_NAME;
    if (roll < 60) return PLAN_EMPTY;
    if (roll < 70) return PLAN_SHORT;
    if (roll < 80) return PLAN_TWICE;
    return PLAN_NONE;
  endfunction

  function automatic int pick_pause(input bit calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Request driver.

  int          gap_left = 0;
  bit          calm_in = 1'b0;
  stream_byte_t next_req;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predicted_results.push_back(sni_predict(data_byte_i, new_stream_i));
        bytes_sent++;
        if (bytes_sent % 150 == 0) calm_in = ($urandom_range(0, 3) == 0);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (byte_backlog.size() != 0) begin
          next_req = byte_backlog.pop_front();
          data_byte_i <= next_req.data;
          new_stream_i <= next_req.fresh;
          in_valid_i <= 1'b1;
          gap_left = pick_pause(calm_in);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor.

  int   stall_left = 0;
  bit   calm_out = 1'b0;
  logic prev_err_set = 1'b0;

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (results_seen % 170 == 0) calm_out = ($urandom_range(0, 3) == 0);
        if (name_valid_o) name_bytes++;
        if (name_valid_o && name_last_o) names_done++;
        if (error_code_o != ERR_NONE && !prev_err_set) begin
          if (error_code_o == ERR_DUP_SNI) dup_errors++;
          if (error_code_o == ERR_LIST_SHORT) short_errors++;
        end
        prev_err_set = (error_code_o != ERR_NONE);
        if (predicted_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result request with no byte pending: byte=%h total=%h", $realtime,
                     name_byte_o, payload_total_o);
        end else begin
          want = predicted_results.pop_front();
          if (name_valid_o !== want.name_valid || name_byte_o !== want.name_byte ||
              name_last_o !== want.name_last || sni_found_o !== want.sni_found ||
              error_code_o !== want.error_code || payload_total_o !== want.payload_total) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result %0d differs", $realtime, results_seen);
              $display("  got  valid=%b byte=%h last=%b found=%b err=%0d total=%h",
                       name_valid_o, name_byte_o, name_last_o, sni_found_o, error_code_o,
                       payload_total_o);
              $display("  want valid=%b byte=%h last=%b found=%b err=%0d total=%h",
                       want.name_valid, want.name_byte, want.name_last, want.sni_found,
                       want.error_code, want.payload_total);
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        stall_left = pick_pause(calm_out);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    // Short directed opening: field extremes, a skipped record, a skipped handshake
    // in a record of maximum length, and an empty handshake record on a new stream.
    open_stream = 1'b0;
    put_byte(8'hFF);
    put_word(16'h00FF);
    put_word(16'h0002);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(RecHandshake);
    put_word(16'hFF00);
    put_word(16'hFFFF);
    put_byte(8'h00);
    put_byte(8'h00);
    put_word(16'h0002);
    put_byte(8'hAA);
    put_byte(8'h55);
    open_stream = 1'b1;
    put_byte(RecHandshake);
    put_word(16'h0303);
    put_word(16'h0000);

    put_stream(PLAN_NAME);
    put_stream(PLAN_EMPTY);
    put_stream(PLAN_SHORT);
    put_stream(PLAN_TWICE);
    put_stream(PLAN_NONE);
    while (byte_backlog.size() < ByteTarget) begin
      if ($urandom_range(0, 99) < 85) begin
        put_stream(pick_plan());
      end else begin
        open_stream = ($urandom_range(0, 1) == 1);
        put_junk($urandom_range(1, 12));
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (byte_backlog.size() != 0 || in_valid_i) @(posedge clk_i);
    while (predicted_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d stream bytes and checked %0d results, %0d mismatches.", bytes_sent,
             results_seen, mismatches);
    $display("Saw %0d host-name bytes in %0d names, %0d duplicate and %0d short-list errors.",
             name_bytes, names_done, dup_errors, short_errors);
    if (mismatches == 0 && predicted_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Timed out with %0d results outstanding.", predicted_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
